>>> rtl/core/dds_tone_generator_adsr_core_assert.svh
// ----------------------------------------------------------------------------
// DDS tone generator assertion macros
// Shared property forms for the tone generator checkers.
// ----------------------------------------------------------------------------
`ifndef DDS_TONE_GENERATOR_ADSR_CORE_ASSERT_SVH
`define DDS_TONE_GENERATOR_ADSR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define DTGA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone generator check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define DTGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone generator check failed");

`endif

>>> rtl/core/dtga_pkg.sv
// ----------------------------------------------------------------------------
// DDS tone generator package
// Constants, codes, lookup tables and arithmetic helpers of the generator.
// ----------------------------------------------------------------------------
package dtga_pkg;

  localparam int SINE_DEPTH  = 256;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int DECAY_DEPTH = 256;
  localparam int DECAY_AW    = $clog2(DECAY_DEPTH);
  localparam int PHASE_BITS  = 32;
  localparam int DAC_BITS    = 12;
  localparam int ADDR_W      = 5;

  localparam logic [DAC_BITS-1:0] DAC_MID = DAC_BITS'(((1 << DAC_BITS) - 1) / 2);

  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] DECAY_RATIO_Q32 = 64'd4244929412;

  localparam logic [2:0] REG_TONE_STEP   = 3'd0;
  localparam logic [2:0] REG_SECOND_STEP = 3'd1;
  localparam logic [2:0] REG_VOICE_MODE  = 3'd2;
  localparam logic [2:0] REG_VOLUME      = 3'd3;
  localparam logic [2:0] REG_SUSTAIN     = 3'd4;
  localparam logic [2:0] REG_ATTACK      = 3'd5;
  localparam logic [2:0] REG_DECAY       = 3'd6;
  localparam logic [2:0] REG_RELEASE     = 3'd7;

  localparam logic [2:0] WF_SINE   = 3'd0;
  localparam logic [2:0] WF_TRI    = 3'd1;
  localparam logic [2:0] WF_SQUARE = 3'd2;
  localparam logic [2:0] WF_SAW    = 3'd3;
  localparam logic [2:0] WF_HARM   = 3'd4;

  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_BIN  = 2'd1;
  localparam logic [1:0] MOD_AM   = 2'd2;

  localparam logic [2:0] ST_OFF     = 3'd0;
  localparam logic [2:0] ST_ATTACK  = 3'd1;
  localparam logic [2:0] ST_DECAY   = 3'd2;
  localparam logic [2:0] ST_SUSTAIN = 3'd3;
  localparam logic [2:0] ST_RELEASE = 3'd4;

  typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];
  typedef logic [15:0] decay_tab_t [DECAY_DEPTH];
  typedef logic [14:0] harm_tab_t [4];

  localparam harm_tab_t HARM_W = '{15'd30008, 15'd18546, 15'd11462, 15'd5520};

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic signed [63:0] s;
    logic signed [63:0] v;
    logic [1:0] quad;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      p = (64'(i) << 32) / SINE_DEPTH;
      quad = p[31:30];
      f = p & 64'h3FFF_FFFF;
      if (quad[0]) f = (64'd1 << 30) - f;
      th = (f * HALF_PI_Q30) >> 30;
      th2 = (th * th) >> 30;
      term = th;
      s = $signed(th);
      for (int k = 1; k <= 7; k++) begin
        term = (term * th2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) s = s - $signed(term);
        else s = s + $signed(term);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      v = (s * 64'sd32767) >>> 30;
      if (v > 64'sd32767) v = 64'sd32767;
      t[i] = quad[1] ? 16'(-v) : 16'(v);
    end
    return t;
  endfunction

  function automatic decay_tab_t build_decay();
    decay_tab_t t;
    logic [63:0] e;
    logic [63:0] r;
    e = 64'd1 << 32;
    for (int i = 0; i < DECAY_DEPTH; i++) begin
      r = (e + 64'd32768) >> 16;
      t[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
      e = (e * DECAY_RATIO_Q32 + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sine_tab_t  SINE_ROM  = build_sine();
  localparam decay_tab_t DECAY_ROM = build_decay();

  function automatic logic signed [50:0] shr_tz(input logic signed [50:0] v,
                                                input logic [5:0] k);
    logic [50:0] m;
    m = v[50] ? 51'(-v) : 51'(v);
    m = m >> k;
    return v[50] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    if (v > 51'sd32767) return 16'sd32767;
    if (v < -51'sd32767) return -16'sd32767;
    return v[15:0];
  endfunction

endpackage

>>> rtl/core/dds_tone_generator_adsr_core.sv
// ----------------------------------------------------------------------------
// DDS tone generator with ADSR envelope
// Phase accumulator oscillator, five waveforms, binaural or AM second
// oscillator, ADSR envelope, volume and DAC offset in one sequenced datapath.
// ----------------------------------------------------------------------------
// Each accepted item is one sample tick and yields one DAC sample. A tick with
// the generator off goes straight to the output state; the length of an active
// tick is set mostly by the 16-step shared restoring divider, which serves the
// envelope position, and by the single shared multiplier, which runs one
// product per cycle: envelope table, triangle or saw, four harmonic terms, AM,
// envelope scaling, volume and the reciprocal for the division by 255 in turn.
// The input is held off while a tick is in work; a finished sample waits in the
// output register and the next tick is taken meanwhile; a tick only ends once
// that register is free. Configuration is to be written through the APB port
// while the block is idle; the block itself does not enforce this.
module dds_tone_generator_adsr_core import dtga_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                note_start,
  input  logic                note_stop,
  input  logic                gen_enable,
  input  logic                gen_disable,
  input  logic                ms_tick,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DAC_BITS-1:0] dac_sample,
  output logic [2:0]          env_phase,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ENV   = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_ENV2  = 5'd3;
  localparam logic [4:0] S_ENV3  = 5'd4;
  localparam logic [4:0] S_WAVE  = 5'd5;
  localparam logic [4:0] S_WSH   = 5'd6;
  localparam logic [4:0] S_HARM  = 5'd7;
  localparam logic [4:0] S_HACC  = 5'd8;
  localparam logic [4:0] S_HFIN  = 5'd9;
  localparam logic [4:0] S_MOD   = 5'd10;
  localparam logic [4:0] S_AM1   = 5'd11;
  localparam logic [4:0] S_AM2   = 5'd12;
  localparam logic [4:0] S_AM3   = 5'd13;
  localparam logic [4:0] S_ENVM  = 5'd14;
  localparam logic [4:0] S_ENVM2 = 5'd15;
  localparam logic [4:0] S_VOL   = 5'd16;
  localparam logic [4:0] S_VOL2  = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;
  localparam logic [4:0] S_RCP   = 5'd20;
  localparam logic [4:0] S_RCP2  = 5'd21;

  localparam logic signed [17:0] RECIP_255 = 18'sd65794;

  logic [31:0] tone_step;
  logic [31:0] second_step;
  logic [12:0] voice_mode;
  logic [7:0]  volume;
  logic [15:0] sustain_lvl;
  logic [15:0] attack_len;
  logic [15:0] decay_len;
  logic [15:0] release_len;

  logic [4:0]  state;
  logic [4:0]  ret;
  logic [PHASE_BITS-1:0] phase_accum;
  logic [31:0] second_phase;
  logic [2:0]  stage;
  logic [15:0] elapsed;
  logic [15:0] level;
  logic        gen_on;
  logic signed [15:0] samp;
  logic signed [33:0] acc;
  logic [1:0]  hcnt;
  logic [15:0] rem;
  logic [15:0] dq;
  logic [15:0] den;
  logic [3:0]  dcnt;
  logic        neg;
  logic [22:0] xmag;
  logic [DAC_BITS-1:0] dac_res;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;

  logic [15:0] ev_elapsed;
  logic [2:0]  ev_stage;
  logic        ev_gen;
  logic [31:0] f;
  logic [2:0]  wf;
  logic [1:0]  md;
  logic [7:0]  depth;
  logic [31:0] sp_next;
  logic signed [15:0] sine_f;
  logic signed [15:0] sine_sp;
  logic signed [15:0] sine_h;
  logic [31:0] hphase;
  logic [16:0] dec_a;
  logic [15:0] rom_val;
  logic signed [32:0] wave_a;
  logic signed [50:0] sh16;
  logic signed [50:0] sh23;
  logic signed [50:0] sh30;
  logic signed [50:0] sh31;
  logic [17:0] dec_sum;
  logic signed [16:0] bsum;
  logic signed [16:0] bmag;
  logic signed [16:0] bhalf;
  logic [50:0] vmag;
  logic [16:0] div_t;
  logic        div_ge;
  logic [15:0] rcp_q;
  logic [23:0] rcp_back;
  logic [15:0] rcp_fix;
  logic signed [16:0] fin_s;
  logic signed [17:0] fin_sum;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (paddr[4:2])
      REG_TONE_STEP:   prdata = tone_step;
      REG_SECOND_STEP: prdata = second_step;
      REG_VOICE_MODE:  prdata = {19'd0, voice_mode};
      REG_VOLUME:      prdata = {24'd0, volume};
      REG_SUSTAIN:     prdata = {16'd0, sustain_lvl};
      REG_ATTACK:      prdata = {16'd0, attack_len};
      REG_DECAY:       prdata = {16'd0, decay_len};
      REG_RELEASE:     prdata = {16'd0, release_len};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step   <= '0;
      second_step <= '0;
      voice_mode  <= '0;
      volume      <= 8'd200;
      sustain_lvl <= 16'd32768;
      attack_len  <= 16'd10;
      decay_len   <= 16'd100;
      release_len <= 16'd200;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TONE_STEP:   tone_step   <= pwdata;
        REG_SECOND_STEP: second_step <= pwdata;
        REG_VOICE_MODE:  voice_mode  <= pwdata[12:0];
        REG_VOLUME:      volume      <= pwdata[7:0];
        REG_SUSTAIN:     sustain_lvl <= pwdata[15:0];
        REG_ATTACK:      attack_len  <= pwdata[15:0];
        REG_DECAY:       decay_len   <= pwdata[15:0];
        REG_RELEASE:     release_len <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    ev_elapsed = (ms_tick && elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    ev_stage = stage;
    if (note_start) begin
      ev_stage = ST_ATTACK;
      ev_elapsed = '0;
    end
    if (note_stop && ev_stage >= ST_ATTACK && ev_stage <= ST_SUSTAIN) begin
      ev_stage = ST_RELEASE;
      ev_elapsed = '0;
    end
    ev_gen = gen_on || gen_enable;
    if (gen_disable) begin
      ev_gen = 1'b0;
      ev_stage = ST_OFF;
    end
  end

  always_comb begin
    f = phase_accum[PHASE_BITS-1 -: 32];
    wf = voice_mode[2:0];
    md = voice_mode[4:3];
    depth = voice_mode[12:5];
    sp_next = second_phase + second_step;
    sine_f = SINE_ROM[f[31 -: SINE_AW]];
    sine_sp = SINE_ROM[sp_next[31 -: SINE_AW]];
    case (hcnt)
      2'd0:    hphase = f;
      2'd1:    hphase = f << 1;
      2'd2:    hphase = f + (f << 1);
      default: hphase = f << 2;
    endcase
    sine_h = SINE_ROM[hphase[31 -: SINE_AW]];
    dec_a = 17'h10000 - {1'b0, sustain_lvl};
    rom_val = DECAY_ROM[dq[DECAY_AW-1:0]];
    if (wf == WF_SAW) wave_a = $signed({1'b0, f}) - 33'sd2147483648;
    else if (f < 32'h4000_0000) wave_a = $signed({1'b0, f});
    else if (f < 32'hC000_0000) wave_a = 33'sd2147483648 - $signed({1'b0, f});
    else wave_a = $signed({1'b1, f});
    sh16 = shr_tz(prod, 6'd16);
    sh23 = shr_tz(prod, 6'd23);
    sh30 = shr_tz(prod, 6'd30);
    sh31 = shr_tz(prod, 6'd31);
    dec_sum = {2'b00, sustain_lvl} + 18'(prod[33:16]);
    bsum = {samp[15], samp} + {sine_sp[15], sine_sp};
    bmag = bsum[16] ? -bsum : bsum;
    bhalf = bsum[16] ? -(bmag >>> 1) : (bmag >>> 1);
    vmag = prod[50] ? 51'(-prod) : 51'(prod);
    div_t = {rem, dq[15]};
    div_ge = (div_t >= {1'b0, den});
    rcp_q = prod[39:24];
    rcp_back = {rcp_q, 8'd0} - {8'd0, rcp_q};
    rcp_fix = (rcp_back > {1'b0, xmag}) ? rcp_q - 16'd1 : rcp_q;
    fin_s = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    fin_sum = {fin_s[16], fin_s} + 18'sd32767;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ENV2: begin
        mul_b = $signed({2'b00, rom_val});
        if (stage == ST_DECAY) mul_a = $signed({16'd0, dec_a});
        else mul_a = $signed({17'd0, sustain_lvl});
      end
      S_WAVE: begin
        mul_a = wave_a;
        mul_b = 18'sd32767;
      end
      S_HARM: begin
        mul_a = 33'(sine_h);
        mul_b = $signed({3'b000, HARM_W[hcnt]});
      end
      S_MOD: begin
        mul_a = $signed({25'd0, depth});
        mul_b = 18'(sine_sp);
      end
      S_AM2: begin
        mul_a = acc[32:0];
        mul_b = 18'(samp);
      end
      S_ENVM: begin
        mul_a = 33'(samp);
        mul_b = $signed({2'b00, level});
      end
      S_VOL: begin
        mul_a = 33'(samp);
        mul_b = $signed({10'd0, volume});
      end
      S_RCP: begin
        mul_a = $signed({10'd0, xmag});
        mul_b = RECIP_255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      phase_accum  <= '0;
      second_phase <= '0;
      stage        <= ST_OFF;
      elapsed      <= '0;
      level        <= '0;
      gen_on       <= 1'b1;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            elapsed <= ev_elapsed;
            stage   <= ev_stage;
            gen_on  <= ev_gen;
            if (gen_disable) level <= '0;
            if (ev_gen) begin
              state <= S_ENV;
            end else begin
              dac_res <= DAC_MID;
              state   <= S_OUT;
            end
          end
        end
        S_ENV: begin
          dcnt <= 4'd15;
          ret  <= S_ENV2;
          case (stage)
            ST_ATTACK: begin
              if (elapsed < attack_len) begin
                rem   <= elapsed;
                dq    <= '0;
                den   <= attack_len;
                state <= S_DIV;
              end else begin
                stage   <= ST_DECAY;
                elapsed <= '0;
                state   <= S_WAVE;
              end
            end
            ST_DECAY: begin
              if (elapsed < decay_len) begin
                rem   <= {8'd0, elapsed[15:8]};
                dq    <= {elapsed[7:0], 8'd0};
                den   <= decay_len;
                state <= S_DIV;
              end else begin
                stage <= ST_SUSTAIN;
                level <= sustain_lvl;
                state <= S_WAVE;
              end
            end
            ST_SUSTAIN: begin
              level <= sustain_lvl;
              state <= S_WAVE;
            end
            ST_RELEASE: begin
              if (elapsed < release_len) begin
                rem   <= {8'd0, elapsed[15:8]};
                dq    <= {elapsed[7:0], 8'd0};
                den   <= release_len;
                state <= S_DIV;
              end else begin
                stage <= ST_OFF;
                level <= '0;
                state <= S_WAVE;
              end
            end
            default: begin
              stage <= ST_OFF;
              level <= '0;
              state <= S_WAVE;
            end
          endcase
        end
        S_DIV: begin
          rem <= div_ge ? 16'(div_t - {1'b0, den}) : div_t[15:0];
          dq  <= {dq[14:0], div_ge};
          if (dcnt == 4'd0) state <= ret;
          else dcnt <= dcnt - 4'd1;
        end
        S_ENV2: begin
          if (stage == ST_ATTACK) begin
            level <= dq;
            state <= S_WAVE;
          end else begin
            state <= S_ENV3;
          end
        end
        S_ENV3: begin
          if (stage == ST_DECAY) level <= (dec_sum > 18'd65535) ? 16'hFFFF : dec_sum[15:0];
          else level <= prod[31:16];
          state <= S_WAVE;
        end
        S_WAVE: begin
          case (wf)
            WF_SINE: begin
              samp  <= sine_f;
              state <= S_MOD;
            end
            WF_SQUARE: begin
              samp  <= f[31] ? -16'sd32767 : 16'sd32767;
              state <= S_MOD;
            end
            WF_TRI, WF_SAW: state <= S_WSH;
            WF_HARM: begin
              acc   <= '0;
              hcnt  <= '0;
              state <= S_HARM;
            end
            default: begin
              samp  <= '0;
              state <= S_MOD;
            end
          endcase
        end
        S_WSH: begin
          samp  <= (wf == WF_TRI) ? sh30[15:0] : sh31[15:0];
          state <= S_MOD;
        end
        S_HARM: state <= S_HACC;
        S_HACC: begin
          acc <= acc + prod[33:0];
          if (hcnt == 2'd3) begin
            state <= S_HFIN;
          end else begin
            hcnt  <= hcnt + 2'd1;
            state <= S_HARM;
          end
        end
        S_HFIN: begin
          samp  <= sat16(shr_tz({{17{acc[33]}}, acc}, 6'd16));
          state <= S_MOD;
        end
        S_MOD: begin
          case (md)
            MOD_BIN: begin
              second_phase <= sp_next;
              samp         <= bhalf[15:0];
              state        <= S_ENVM;
            end
            MOD_AM: begin
              second_phase <= sp_next;
              state        <= S_AM1;
            end
            default: state <= S_ENVM;
          endcase
        end
        S_AM1: begin
          acc   <= prod[33:0] + 34'sd8388608;
          state <= S_AM2;
        end
        S_AM2: state <= S_AM3;
        S_AM3: begin
          samp  <= sat16(sh23);
          state <= S_ENVM;
        end
        S_ENVM: state <= S_ENVM2;
        S_ENVM2: begin
          samp  <= sh16[15:0];
          state <= S_VOL;
        end
        S_VOL: state <= S_VOL2;
        S_VOL2: begin
          neg   <= prod[50];
          xmag  <= vmag[22:0];
          state <= S_RCP;
        end
        S_RCP: state <= S_RCP2;
        S_RCP2: begin
          dq    <= rcp_fix;
          state <= S_FIN;
        end
        S_FIN: begin
          dac_res     <= fin_sum[15 -: DAC_BITS];
          phase_accum <= phase_accum + PHASE_BITS'(tone_step);
          state       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            dac_sample <= dac_res;
            env_phase  <= stage;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/dtga_checker.sv
// ----------------------------------------------------------------------------
// DDS tone generator port checker
// Watches the top-level ports of the tone generator over time.
// ----------------------------------------------------------------------------
`include "dds_tone_generator_adsr_core_assert.svh"

module dtga_checker import dtga_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DAC_BITS-1:0] dac_sample,
  input logic [2:0]          env_phase,
  input logic                pready
);

  // A stalled result item keeps its payload.
  `DTGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dac_sample))

  // After an item is taken, the block is busy in the next cycle.
  `DTGA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // With the envelope off, the sample sits at the DAC midpoint.
  `DTGA_ASSERT_SAME(a_off_silent, out_valid && env_phase == ST_OFF, dac_sample == DAC_MID)

  `DTGA_ASSERT_SAME(a_phase_range, out_valid, env_phase <= ST_RELEASE && pready)

endmodule

bind dds_tone_generator_adsr_core dtga_checker u_dtga_checker (.*);
